FILE: design/pai_pkg.sv
// ----------------------------------------------------------------------------
// pai_pkg
// Shared types, widths, register codes and the EMA coefficient table of the
// price average indicators block.
// ----------------------------------------------------------------------------
package pai_pkg;

  // Field and arithmetic widths
  localparam int PRICE_W     = 32;
  localparam int QUOT_W      = 32;
  localparam int QUOT_CNT_W  = $clog2(QUOT_W);
  localparam int COEF_W      = 16;
  localparam int PROD_W      = PRICE_W + COEF_W;
  localparam int MACD_W      = 33;
  localparam int ONE_Q16     = 65536;
  localparam int ROUND_HALF  = 32768;
  localparam int EMA_COUNT   = 3;
  localparam int EMA_SEL_W   = 2;

  // Stream and configuration port widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 200;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int LWIN_CFG_W  = 11;
  localparam int SWIN_CFG_W  = 8;
  localparam int PERIOD_W    = 8;

  // Default ring depths
  localparam int LONG_DEPTH_DEF  = 1024;
  localparam int SHORT_DEPTH_DEF = 128;

  // Register reset values
  localparam logic [LWIN_CFG_W-1:0] LONG_WINDOW_RST  = 11'd1000;
  localparam logic [SWIN_CFG_W-1:0] SHORT_WINDOW_RST = 8'd100;
  localparam logic [PERIOD_W-1:0]   PERIOD_A_RST     = 8'd9;
  localparam logic [PERIOD_W-1:0]   PERIOD_B_RST     = 8'd12;
  localparam logic [PERIOD_W-1:0]   PERIOD_C_RST     = 8'd26;

  // Register indexes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LONG_WINDOW  = 3'd0,
    REG_SHORT_WINDOW = 3'd1,
    REG_PERIOD_A     = 3'd2,
    REG_PERIOD_B     = 3'd3,
    REG_PERIOD_C     = 3'd4
  } cfg_reg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic update;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic ema_done;
  } status_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic [4:0]               pad;
    logic                     short_full;
    logic                     long_full;
    logic signed [MACD_W-1:0] macd_value;
    logic [PRICE_W-1:0]       ema_c;
    logic [PRICE_W-1:0]       ema_b;
    logic [PRICE_W-1:0]       ema_a;
    logic [PRICE_W-1:0]       short_mean;
    logic [PRICE_W-1:0]       long_mean;
  } out_item_t;

  // EMA coefficient k = round(65536 / (period + 1)), period zero taken as one
  typedef logic [COEF_W-1:0] k_table_t [256];

  function automatic k_table_t build_k_table();
    k_table_t   tbl;
    logic [17:0] num;
    logic [17:0] den;
    logic [17:0] rem;
    logic [17:0] quo;
    for (int p = 0; p < 256; p++) begin
      den = (p == 0) ? 18'd2 : 18'(p + 1);
      num = 18'(ONE_Q16) + (den >> 1);
      rem = '0;
      quo = '0;
      // Long division by repeated compare and subtract
      for (int b = 17; b >= 0; b--) begin
        rem = {rem[16:0], num[b]};
        if (rem >= den) begin
          rem    = rem - den;
          quo[b] = 1'b1;
        end
      end
      tbl[p] = quo[COEF_W-1:0];
    end
    return tbl;
  endfunction

  localparam k_table_t K_TABLE = build_k_table();

endpackage

FILE: design/pai_ram.sv
// ----------------------------------------------------------------------------
// pai_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pai_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/pai_div.sv
// ----------------------------------------------------------------------------
// pai_div
// Bit-serial restoring divider for a window sum by the window size. The
// quotient is known to fit QUOT_W bits, so the top bits of the dividend seed
// the remainder and one quotient bit is retired per cycle.
// ----------------------------------------------------------------------------
module pai_div #(
  parameter int DEN_W = 11
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [pai_pkg::QUOT_W+DEN_W-1:0]  dividend,
  input  logic [DEN_W-1:0]                  divisor,
  output logic                              done,
  output logic [pai_pkg::QUOT_W-1:0]        quotient
);

  import pai_pkg::*;

  logic [DEN_W-1:0]      rem_r;
  logic [DEN_W-1:0]      rem_nxt;
  logic [QUOT_W-1:0]     quo_r;
  logic [DEN_W-1:0]      den_r;
  logic [QUOT_CNT_W-1:0] cnt_r;
  logic                  busy_r;
  logic [DEN_W:0]        trial;
  logic [DEN_W:0]        diff;
  logic                  ge;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial   = {rem_r, quo_r[QUOT_W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == QUOT_CNT_W'(QUOT_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[QUOT_W+DEN_W-1:QUOT_W];
      quo_r <= dividend[QUOT_W-1:0];
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QUOT_W-2:0], ge};
    end
  end

  assign done     = !busy_r;
  assign quotient = quo_r;

endmodule

FILE: design/pai_win.sv
// ----------------------------------------------------------------------------
// pai_win
// One sliding window: price ring in RAM, running sum, fill count, write
// pointer and the divider that turns the sum into a mean.
// ----------------------------------------------------------------------------
module pai_win #(
  parameter int DEPTH = 1024,
  parameter int CFG_W = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  logic [CFG_W-1:0]             cfg_size,
  input  logic [pai_pkg::PRICE_W-1:0]  price,
  input  logic                         update,
  output logic                         full,
  output logic [pai_pkg::PRICE_W-1:0]  mean,
  output logic                         done
);

  import pai_pkg::*;

  localparam int SIZE_W = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int SUM_W  = QUOT_W + SIZE_W;
  localparam int WIDE_W = ((CFG_W > SIZE_W) ? CFG_W : SIZE_W) + 1;

  logic [IDX_W-1:0]   head_r;
  logic [SIZE_W-1:0]  fill_r;
  logic [SIZE_W-1:0]  fill_nxt;
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_nxt;
  logic               full_r;
  logic [SIZE_W-1:0]  size;
  logic [SIZE_W:0]    old_pos;
  logic [IDX_W-1:0]   old_idx;
  logic [PRICE_W-1:0] old_price;
  logic               at_size;
  logic [QUOT_W-1:0]  quotient;

  // Clamp the window register to 1..DEPTH
  always_comb begin
    if (cfg_size == '0) begin
      size = SIZE_W'(1);
    end else if (WIDE_W'(cfg_size) > WIDE_W'(DEPTH)) begin
      size = SIZE_W'(DEPTH);
    end else begin
      size = SIZE_W'(cfg_size);
    end
  end

  // Ring slot that leaves the window
  always_comb begin
    if ((SIZE_W + 1)'(head_r) >= (SIZE_W + 1)'(size)) begin
      old_pos = (SIZE_W + 1)'(head_r) - (SIZE_W + 1)'(size);
    end else begin
      old_pos = (SIZE_W + 1)'(head_r) + (SIZE_W + 1)'(DEPTH) - (SIZE_W + 1)'(size);
    end
    old_idx = old_pos[IDX_W-1:0];
  end

  pai_ram #(
    .WIDTH (PRICE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (update),
    .wr_addr (head_r),
    .wr_data (price),
    .rd_addr (old_idx),
    .rd_data (old_price)
  );

  // Next sum and fill
  always_comb begin
    at_size  = (fill_r >= size);
    fill_nxt = at_size ? fill_r : fill_r + 1'b1;
    sum_nxt  = sum_r - (at_size ? SUM_W'(old_price) : '0) + SUM_W'(price);
  end

  // Window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
      sum_r  <= '0;
      full_r <= 1'b0;
    end else if (clear) begin
      fill_r <= '0;
      sum_r  <= '0;
      full_r <= 1'b0;
    end else if (update) begin
      head_r <= (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
      full_r <= (fill_nxt >= size);
    end
  end

  pai_div #(
    .DEN_W (SIZE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (update),
    .dividend (sum_nxt),
    .divisor  (size),
    .done     (done),
    .quotient (quotient)
  );

  assign full = full_r;
  assign mean = full_r ? quotient : '0;

endmodule

FILE: design/pai_ctrl.sv
// ----------------------------------------------------------------------------
// pai_ctrl
// Controller: takes a request, runs the window update, waits for the means
// and EMAs, and hands the result to the output register.
// ----------------------------------------------------------------------------
module pai_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  pai_pkg::status_t  status,
  output pai_pkg::cmd_t     cmd
);

  import pai_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_UPDATE = 3'b010,
    ST_RUN    = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_RUN;
      end
      ST_RUN: begin
        if (status.div_done && status.ema_done && (!out_valid_r || out_tready)) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

FILE: design/pai_datapath.sv
// ----------------------------------------------------------------------------
// pai_datapath
// Datapath: configuration registers, the two sliding windows, the three EMAs
// on one shared multiplier, and the result register.
// ----------------------------------------------------------------------------
module pai_datapath #(
  parameter int LONG_DEPTH  = pai_pkg::LONG_DEPTH_DEF,
  parameter int SHORT_DEPTH = pai_pkg::SHORT_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [pai_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [pai_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [pai_pkg::PRICE_W-1:0]     price,
  input  pai_pkg::cmd_t                   cmd,
  output pai_pkg::status_t                status,
  output pai_pkg::out_item_t              out_item
);

  import pai_pkg::*;

  typedef enum logic [2:0] {
    PH_MUL_PRICE = 3'b001,
    PH_MUL_PREV  = 3'b010,
    PH_WRITE     = 3'b100
  } ema_phase_t;

  logic [LWIN_CFG_W-1:0] long_window_r;
  logic [SWIN_CFG_W-1:0] short_window_r;
  logic [PERIOD_W-1:0]   period_a_r;
  logic [PERIOD_W-1:0]   period_b_r;
  logic [PERIOD_W-1:0]   period_c_r;
  logic                  long_clear;
  logic                  short_clear;

  logic [PRICE_W-1:0]    price_r;

  logic                  long_full;
  logic                  short_full;
  logic [PRICE_W-1:0]    long_mean;
  logic [PRICE_W-1:0]    short_mean;
  logic                  long_done;
  logic                  short_done;

  logic [PRICE_W-1:0]    ema_r [EMA_COUNT];
  logic [EMA_SEL_W-1:0]  ema_sel_r;
  ema_phase_t            ema_ph_r;
  logic                  ema_busy_r;
  logic [PROD_W-1:0]     prod_r;
  logic [PROD_W-1:0]     acc_r;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     ema_sum;
  logic [PERIOD_W-1:0]   period;
  logic [COEF_W-1:0]     k;
  logic [COEF_W-1:0]     k_comp;
  logic [COEF_W:0]       k_comp_wide;
  logic [PRICE_W-1:0]    mul_a;
  logic [COEF_W-1:0]     mul_b;

  out_item_t             out_item_r;

  // Configuration registers; a window write restarts that window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_window_r  <= LONG_WINDOW_RST;
      short_window_r <= SHORT_WINDOW_RST;
      period_a_r     <= PERIOD_A_RST;
      period_b_r     <= PERIOD_B_RST;
      period_c_r     <= PERIOD_C_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_LONG_WINDOW:  long_window_r  <= cfg_wdata[LWIN_CFG_W-1:0];
        REG_SHORT_WINDOW: short_window_r <= cfg_wdata[SWIN_CFG_W-1:0];
        REG_PERIOD_A:     period_a_r     <= cfg_wdata[PERIOD_W-1:0];
        REG_PERIOD_B:     period_b_r     <= cfg_wdata[PERIOD_W-1:0];
        REG_PERIOD_C:     period_c_r     <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign long_clear  = cfg_wr_en && (cfg_addr == REG_LONG_WINDOW);
  assign short_clear = cfg_wr_en && (cfg_addr == REG_SHORT_WINDOW);

  // Hold the accepted price
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      price_r <= price;
    end
  end

  pai_win #(
    .DEPTH (LONG_DEPTH),
    .CFG_W (LWIN_CFG_W)
  ) u_long (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (long_clear),
    .cfg_size (long_window_r),
    .price    (price_r),
    .update   (cmd.update),
    .full     (long_full),
    .mean     (long_mean),
    .done     (long_done)
  );

  pai_win #(
    .DEPTH (SHORT_DEPTH),
    .CFG_W (SWIN_CFG_W)
  ) u_short (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (short_clear),
    .cfg_size (short_window_r),
    .price    (price_r),
    .update   (cmd.update),
    .full     (short_full),
    .mean     (short_mean),
    .done     (short_done)
  );

  // Coefficient of the EMA in turn
  always_comb begin
    case (ema_sel_r)
      2'd0:    period = period_a_r;
      2'd1:    period = period_b_r;
      default: period = period_c_r;
    endcase
    k           = K_TABLE[period];
    k_comp_wide = (COEF_W + 1)'(ONE_Q16) - (COEF_W + 1)'(k);
    k_comp      = k_comp_wide[COEF_W-1:0];
  end

  // Shared multiplier: price times k, then previous EMA times (1 - k)
  always_comb begin
    if (ema_ph_r == PH_MUL_PRICE) begin
      mul_a = price_r;
      mul_b = k;
    end else begin
      mul_a = ema_r[ema_sel_r];
      mul_b = k_comp;
    end
    prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    ema_sum = acc_r + prod_r;
  end

  // EMA sequencer: three phases for each of the three averages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ema_busy_r <= 1'b0;
      ema_sel_r  <= '0;
      ema_ph_r   <= PH_MUL_PRICE;
      for (int i = 0; i < EMA_COUNT; i++) begin
        ema_r[i] <= '0;
      end
    end else if (cmd.update) begin
      ema_busy_r <= 1'b1;
      ema_sel_r  <= '0;
      ema_ph_r   <= PH_MUL_PRICE;
    end else if (ema_busy_r) begin
      case (ema_ph_r)
        PH_MUL_PRICE: begin
          ema_ph_r <= PH_MUL_PREV;
        end
        PH_MUL_PREV: begin
          ema_ph_r <= PH_WRITE;
        end
        PH_WRITE: begin
          ema_r[ema_sel_r] <= ema_sum[PROD_W-1:COEF_W];
          ema_ph_r         <= PH_MUL_PRICE;
          if (ema_sel_r == EMA_SEL_W'(EMA_COUNT - 1)) begin
            ema_busy_r <= 1'b0;
          end else begin
            ema_sel_r <= ema_sel_r + 1'b1;
          end
        end
        default: begin
          ema_ph_r <= PH_MUL_PRICE;
        end
      endcase
    end
  end

  // Product and rounding accumulator
  always_ff @(posedge clk) begin
    if (ema_busy_r) begin
      if (ema_ph_r == PH_MUL_PREV) begin
        acc_r <= prod_r + PROD_W'(ROUND_HALF);
      end
      prod_r <= prod;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.pad        <= '0;
      out_item_r.short_full <= short_full;
      out_item_r.long_full  <= long_full;
      out_item_r.macd_value <= {1'b0, ema_r[1]} - {1'b0, ema_r[2]};
      out_item_r.ema_c      <= ema_r[2];
      out_item_r.ema_b      <= ema_r[1];
      out_item_r.ema_a      <= ema_r[0];
      out_item_r.short_mean <= short_mean;
      out_item_r.long_mean  <= long_mean;
    end
  end

  assign status.div_done = long_done && short_done;
  assign status.ema_done = !ema_busy_r;
  assign out_item        = out_item_r;

endmodule

FILE: design/price_average_indicators_unit.sv
// One price at a time: a new price is taken only once the last result has gone
// to the output register, and that load waits while a result is not taken.
// The 32-step bit-serial divider behind each window mean sets the pace; the
// three EMAs share one 32x16 multiplier and finish within it.
// Reset (rst_n low, synchronous): sums, fill counts, ring pointers and EMAs go
// to zero and registers to defaults; ring RAMs are not cleared, no sweep.
// ----------------------------------------------------------------------------
// price_average_indicators_unit
// Long and short sliding means, three EMAs and MACD over a stream of prices.
// ----------------------------------------------------------------------------
module price_average_indicators_unit #(
  parameter int LONG_DEPTH  = pai_pkg::LONG_DEPTH_DEF,
  parameter int SHORT_DEPTH = pai_pkg::SHORT_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // price [31:0]
  input  logic [pai_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // long_mean [31:0], short_mean [63:32], ema_a [95:64], ema_b [127:96],
  // ema_c [159:128], macd_value [192:160], long_full [193], short_full [194]
  output logic [pai_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_wr_en,
  input  logic [pai_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pai_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import pai_pkg::*;

  cmd_t      cmd;
  status_t   status;
  out_item_t out_item;

  pai_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  pai_datapath #(
    .LONG_DEPTH  (LONG_DEPTH),
    .SHORT_DEPTH (SHORT_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .price     (in_tdata[PRICE_W-1:0]),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

  assign out_tdata = out_item;

endmodule
